>>> rtl/core/pbt_pkg.sv
// pbt_pkg: shared types and constants of the playback position tracker
// no dependencies; imported by all rtl/core modules of the tracker

package pbt_pkg;

  // fixed port widths
  localparam int OPERAND_BITS = 32;
  localparam int CMD_BITS     = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 32;
  localparam int OUT_BITS     = 40;
  localparam int RATE_BITS    = 16;

  // play rate after reset, 1.0 in the default rate format
  localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_ENABLE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_RATE   = 2'd2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PLAY   = 3'd0,
    CMD_RESET  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_SEEK   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    RS_INIT      = 2'd0,
    RS_PLAYING   = 2'd1,
    RS_PAUSED    = 2'd2,
    RS_COMPLETED = 2'd3
  } run_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_MUL,
    FSM_SUM,
    FSM_DIV,
    FSM_DONE
  } fsm_t;

endpackage

>>> rtl/core/playback_position_tracker.sv
// playback_position_tracker: top level, command sequencer and result register
// depends on pbt_pkg, pbt_mul, pbt_rem

// Tracks a playback position (unsigned, 16 fraction bits) through the run
// states init, playing, paused and completed. One command is taken at a
// time and gives one result. Play, reset, pause, resume, unused codes, a
// tick while not playing and a seek without loop mode or with a zero clip
// length pass from the evaluate state to the done state. A tick while
// playing runs the serial multiplier, one rate bit per cycle; when it
// runs past the clip end in loop mode, or on a seek in loop mode, the
// serial remainder unit then runs, one dividend bit per cycle, if the
// clip length is not zero. A result may wait in the output register
// while the next command is taken.

module playback_position_tracker #(
  parameter int TIME_BITS      = 32,
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pbt_pkg::OPERAND_BITS-1:0]  s_tdata,   // time_operand
  input  logic [pbt_pkg::CMD_BITS-1:0]      s_tuser,   // command
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pbt_pkg::OUT_BITS-1:0]      m_tdata,   // run_state_out, position_out, wrapped
  input  logic                              cfg_we,
  input  logic [pbt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pbt_pkg::CFG_BITS-1:0]      cfg_data
);
  import pbt_pkg::*;

  localparam int WIDE      = (TIME_BITS > OPERAND_BITS) ? TIME_BITS : OPERAND_BITS;
  localparam int PROD_BITS = TIME_BITS + RATE_BITS;
  localparam int STEP_BITS = PROD_BITS - RATE_FRAC_BITS;
  localparam int SUM_BITS  = STEP_BITS + 1;

  // configuration
  logic [TIME_BITS-1:0] clip_len;
  logic                 loop_en;
  logic [RATE_BITS-1:0] play_rate;
  logic [WIDE-1:0]      cfg_wide;

  // sequencer and tracker state
  fsm_t                 fsm, fsm_next;
  cmd_t                 cmd, cmd_next;
  logic [TIME_BITS-1:0] operand, operand_next;
  run_state_t           run_state, run_state_next;
  logic [TIME_BITS-1:0] position, position_next;
  logic                 looped, looped_next;
  logic                 out_load;
  logic [WIDE-1:0]      op_wide;
  logic [WIDE-1:0]      pos_wide;

  // arithmetic
  logic                 mul_start, mul_done;
  logic [PROD_BITS-1:0] product;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  sum;
  logic [TIME_BITS-1:0] sum_sat;
  logic [TIME_BITS-1:0] len_m1;
  logic                 rem_start, rem_done;
  logic [TIME_BITS-1:0] rem_dividend;
  logic [TIME_BITS-1:0] remainder;

  assign cfg_wide = WIDE'(cfg_data);
  assign op_wide  = WIDE'(s_tdata);
  assign pos_wide = WIDE'(position);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_len  <= '0;
      loop_en   <= 1'b0;
      play_rate <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LENGTH: clip_len  <= cfg_wide[TIME_BITS-1:0];
        CFG_LOOP_ENABLE: loop_en   <= cfg_data[0];
        CFG_PLAY_RATE:   play_rate <= cfg_data[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  pbt_mul #(
    .A_BITS(TIME_BITS)
  ) u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (operand),
    .multiplier   (play_rate),
    .done         (mul_done),
    .product      (product)
  );

  pbt_rem #(
    .W(TIME_BITS)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (clip_len),
    .done      (rem_done),
    .remainder (remainder)
  );

  // advance, saturated to the top of the time range
  assign step    = product[PROD_BITS-1:RATE_FRAC_BITS];
  assign sum     = SUM_BITS'(position) + SUM_BITS'(step);
  assign sum_sat = (sum[SUM_BITS-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}}
                                                     : sum[TIME_BITS-1:0];
  assign len_m1  = clip_len - 1'b1;

  assign rem_dividend = (fsm == FSM_SUM) ? sum_sat : operand;
  assign s_tready     = (fsm == FSM_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FSM_IDLE;
      cmd       <= CMD_PLAY;
      run_state <= RS_INIT;
      position  <= '0;
      looped    <= 1'b0;
    end else begin
      fsm       <= fsm_next;
      cmd       <= cmd_next;
      run_state <= run_state_next;
      position  <= position_next;
      looped    <= looped_next;
    end
  end

  always_ff @(posedge clk) begin
    operand <= operand_next;
  end

  // command sequencing
  always_comb begin
    fsm_next       = fsm;
    cmd_next       = cmd;
    operand_next   = operand;
    run_state_next = run_state;
    position_next  = position;
    looped_next    = looped;
    mul_start      = 1'b0;
    rem_start      = 1'b0;
    out_load       = 1'b0;
    case (fsm)
      FSM_IDLE: begin
        if (s_tvalid) begin
          cmd_next     = cmd_t'(s_tuser);
          operand_next = op_wide[TIME_BITS-1:0];
          fsm_next     = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        fsm_next = FSM_DONE;
        case (cmd)
          CMD_PLAY: begin
            run_state_next = RS_PLAYING;
            position_next  = operand;
            looped_next    = 1'b0;
          end
          CMD_RESET: begin
            run_state_next = RS_INIT;
            position_next  = '0;
            looped_next    = 1'b0;
          end
          CMD_PAUSE: begin
            if (run_state == RS_PLAYING) begin
              run_state_next = RS_PAUSED;
            end
          end
          CMD_RESUME: begin
            if (run_state == RS_PAUSED) begin
              run_state_next = RS_PLAYING;
            end
          end
          CMD_TICK: begin
            looped_next = 1'b0;
            if (run_state == RS_PLAYING) begin
              mul_start = 1'b1;
              fsm_next  = FSM_MUL;
            end
          end
          CMD_SEEK: begin
            looped_next = 1'b0;
            if (clip_len == '0) begin
              position_next = '0;
            end else if (loop_en) begin
              rem_start = 1'b1;
              fsm_next  = FSM_DIV;
            end else begin
              position_next = (operand < len_m1) ? operand : len_m1;
            end
          end
          default: ;
        endcase
      end
      FSM_MUL: begin
        if (mul_done) begin
          fsm_next = FSM_SUM;
        end
      end
      FSM_SUM: begin
        fsm_next = FSM_DONE;
        if (sum_sat < clip_len) begin
          position_next = sum_sat;
        end else if (loop_en) begin
          looped_next = 1'b1;
          if (clip_len == '0) begin
            position_next = '0;
          end else begin
            rem_start = 1'b1;
            fsm_next  = FSM_DIV;
          end
        end else begin
          position_next  = (clip_len == '0) ? '0 : len_m1;
          run_state_next = RS_COMPLETED;
        end
      end
      FSM_DIV: begin
        if (rem_done) begin
          // a loop seek marks a wrap when it lands behind the old position
          if (cmd == CMD_SEEK) begin
            looped_next = (remainder < position);
          end
          position_next = remainder;
          fsm_next      = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          fsm_next = FSM_IDLE;
        end
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, looped, pos_wide[OPERAND_BITS-1:0], run_state};
    end
  end

endmodule

>>> rtl/core/pbt_mul.sv
// pbt_mul: radix-2 serial multiplier, one bit of the rate per cycle
// depends on pbt_pkg

module pbt_mul #(
  parameter int A_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [A_BITS-1:0]                      multiplicand,
  input  logic [pbt_pkg::RATE_BITS-1:0]          multiplier,
  output logic                                   done,
  output logic [A_BITS+pbt_pkg::RATE_BITS-1:0]   product
);
  import pbt_pkg::*;

  localparam int CNT_BITS = $clog2(RATE_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RATE_BITS - 1);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [A_BITS-1:0]    mcand;
  logic [A_BITS-1:0]    hi;
  logic [RATE_BITS-1:0] lo;
  logic [A_BITS:0]      partial;

  // add the multiplicand when the low multiplier bit is set
  assign partial = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(A_BITS + 1){1'b0}});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product shifts right one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= multiplicand;
      hi    <= '0;
      lo    <= multiplier;
    end else if (busy) begin
      {hi, lo} <= {partial, lo[RATE_BITS-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

>>> rtl/core/pbt_rem.sv
// pbt_rem: restoring serial remainder, one dividend bit per cycle
// depends on pbt_pkg

module pbt_rem #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);
  import pbt_pkg::*;

  localparam int CNT_BITS = $clog2(W);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(W - 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [W-1:0]        num;
  logic [W-1:0]        dvs;
  logic [W-1:0]        rem;
  logic [W:0]          trial;
  logic [W:0]          diff;

  // bring in the next dividend bit and try to subtract
  assign trial = {rem, num[W-1]};
  assign diff  = trial - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[W-2:0], 1'b0};
      rem <= (trial >= {1'b0, dvs}) ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign remainder = rem;

endmodule

>>> bench/tb_playback_position_tracker.sv
// tb_playback_position_tracker: self-checking bench for the playback position tracker
// depends on pbt_pkg and playback_position_tracker; directed and random command
// streams are checked against an in-bench model of the position and run state

module tb_playback_position_tracker;
  import pbt_pkg::*;

  // longest quiet stretch is the long output hold plus a remainder pass
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 100;
  localparam int RATE_FRAC      = 8;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_B = 3'd7;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    run_state_t  state;
    logic [31:0] position;
    logic        wrapped;
  } status_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [OPERAND_BITS-1:0]   s_tdata;   // time_operand
  logic [CMD_BITS-1:0]       s_tuser;   // command
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_BITS-1:0]       m_tdata;   // run_state_out, position_out, wrapped
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  // model copy of the registers and the tracker state
  logic [31:0] clip_len;
  logic        loop_on;
  logic [15:0] rate;
  run_state_t  trk_state;
  logic [31:0] trk_pos;
  logic        trk_looped;

  status_t pending_status[$];
  int      error_count  = 0;
  int      burst_left   = 0;
  int      hold_request = 0;
  int      idle_cycles  = 0;

  playback_position_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one command to the model and returns the status it reports
  function automatic status_t track_command(input logic [CMD_BITS-1:0] cmd,
                                            input logic [31:0] operand);
    logic [63:0] advance;
    logic [63:0] sum;
    logic [31:0] next_pos;
    status_t     res;
    case (cmd)
      CMD_PLAY: begin
        trk_state  = RS_PLAYING;
        trk_pos    = operand;
        trk_looped = 1'b0;
      end
      CMD_RESET: begin
        trk_state  = RS_INIT;
        trk_pos    = 32'd0;
        trk_looped = 1'b0;
      end
      CMD_PAUSE: begin
        if (trk_state == RS_PLAYING) trk_state = RS_PAUSED;
      end
      CMD_RESUME: begin
        if (trk_state == RS_PAUSED) trk_state = RS_PLAYING;
      end
      CMD_TICK: begin
        trk_looped = 1'b0;
        if (trk_state == RS_PLAYING) begin
          // delta times rate, saturating at the top of the time range
          advance = ({32'd0, operand} * {48'd0, rate}) >> RATE_FRAC;
          sum = {32'd0, trk_pos} + advance;
          if (sum > {32'd0, TIME_MAX}) sum = {32'd0, TIME_MAX};
          trk_pos = sum[31:0];
          // past the clip end: wrap in loop mode, else clamp and complete
          if (trk_pos >= clip_len) begin
            if (loop_on) begin
              trk_looped = 1'b1;
              if (clip_len != 32'd0) trk_pos = trk_pos % clip_len;
              else trk_pos = 32'd0;
            end else begin
              if (clip_len != 32'd0) trk_pos = clip_len - 32'd1;
              else trk_pos = 32'd0;
              trk_state = RS_COMPLETED;
            end
          end
        end
      end
      CMD_SEEK: begin
        trk_looped = 1'b0;
        if (clip_len == 32'd0) begin
          trk_pos = 32'd0;
        end else if (loop_on) begin
          next_pos   = operand % clip_len;
          trk_looped = (next_pos < trk_pos);
          trk_pos    = next_pos;
        end else begin
          trk_pos = (operand < clip_len - 32'd1) ? operand : clip_len - 32'd1;
        end
      end
      default: begin
      end
    endcase
    res.state    = trk_state;
    res.position = trk_pos;
    res.wrapped  = trk_looped;
    return res;
  endfunction

  // offers one command in bursts with random gaps, predicts it on transfer
  task automatic send_command(input logic [CMD_BITS-1:0] cmd, input logic [31:0] operand);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= operand;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_status.push_back(track_command(cmd, operand));
  endtask

  // stops offering and waits until every result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers while the block is idle
  task automatic set_config(input logic [31:0] length, input logic loop,
                            input logic [15:0] speed);
    logic [31:0] junk;
    wait_for_results();
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLIP_LENGTH;
    cfg_data  <= length;
    @(posedge clk);
    cfg_index <= CFG_LOOP_ENABLE;
    cfg_data  <= {junk[31:1], loop};
    @(posedge clk);
    cfg_index <= CFG_PLAY_RATE;
    cfg_data  <= {junk[31:16], speed};
    @(posedge clk);
    cfg_we <= 1'b0;
    clip_len = length;
    loop_on  = loop;
    rate     = speed;
  endtask

  // one random command; ticks mostly aimed at a fraction of the clip
  task automatic send_random_command();
    logic [31:0] operand;
    logic [31:0] raw;
    logic [63:0] target;
    int          pick;
    int          shape;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    raw   = $urandom;
    case (shape)
      0: operand = raw;
      1: operand = ($urandom_range(0, 1) != 0) ? TIME_MAX : 32'd0;
      2: operand = clip_len + $urandom_range(0, 2) - 1;
      default: operand = (clip_len != 32'd0) ? raw % clip_len : raw;
    endcase
    if (pick < 50) begin
      if (shape >= 3 && rate != 16'd0) begin
        target = ({32'd0, raw} % ({32'd0, clip_len} / 8 + 64'd1)) << RATE_FRAC;
        target = target / {48'd0, rate};
        operand = (target > {32'd0, TIME_MAX}) ? TIME_MAX : target[31:0];
      end
      send_command(CMD_TICK, operand);
    end else if (pick < 62) begin
      send_command(CMD_SEEK, operand);
    end else if (pick < 72) begin
      send_command(CMD_PLAY, operand);
    end else if (pick < 81) begin
      send_command(CMD_PAUSE, raw);
    end else if (pick < 90) begin
      send_command(CMD_RESUME, raw);
    end else if (pick < 95) begin
      send_command(CMD_RESET, raw);
    end else begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B, raw);
    end
  endtask

  // commands with no effect from init, at the reset register values
  task automatic test_idle_commands();
    send_command(CMD_TICK, TIME_MAX);
    send_command(CMD_SPARE_A, 32'h1234_5678);
    send_command(CMD_SPARE_B, TIME_MAX);
    send_command(CMD_PAUSE, 32'd0);
    send_command(CMD_RESUME, 32'd0);
  endtask

  // zero clip length, with and without loop mode
  task automatic test_zero_length();
    send_command(CMD_PLAY, 32'h0003_0000);
    send_command(CMD_TICK, 32'd0);
    set_config(32'd0, 1'b1, RATE_RESET);
    send_command(CMD_PLAY, 32'h0005_0000);
    send_command(CMD_TICK, 32'd1);
    send_command(CMD_SEEK, TIME_MAX);
  endtask

  // clamp at clip end, completed state, pause and resume rules
  task automatic test_clamp_complete();
    set_config(32'h000A_0000, 1'b0, 16'hFFFF);
    send_command(CMD_PLAY, 32'd0);
    send_command(CMD_TICK, TIME_MAX);
    send_command(CMD_RESUME, 32'd0);
    send_command(CMD_PLAY, 32'h0005_0000);
    send_command(CMD_PAUSE, 32'd0);
    send_command(CMD_TICK, 32'h0001_0000);
    send_command(CMD_RESUME, 32'd0);
    send_command(CMD_SEEK, TIME_MAX);
    send_command(CMD_PLAY, TIME_MAX);
  endtask

  // wrap by remainder on tick and seek, then the reset command
  task automatic test_loop_wrap();
    set_config(32'h000A_0000, 1'b1, RATE_RESET);
    send_command(CMD_PLAY, 32'h0009_0000);
    send_command(CMD_TICK, 32'h0002_0000);
    send_command(CMD_SEEK, 32'h0014_0000);
    send_command(CMD_RESET, TIME_MAX);
    send_command(CMD_TICK, 32'h0001_0000);
  endtask

  // saturated sum at the largest length and rate
  task automatic test_saturation();
    set_config(TIME_MAX, 1'b1, 16'hFFFF);
    send_command(CMD_PLAY, 32'hFFFF_0000);
    send_command(CMD_TICK, TIME_MAX);
  endtask

  // long output hold while commands keep coming, so the input stalls
  task automatic test_output_stall();
    set_config(32'h0010_0000, 1'b1, RATE_RESET);
    send_command(CMD_PLAY, 32'd0);
    hold_request = 400;
    burst_left   = 1000;
    repeat (40) send_random_command();
    wait_for_results();
  endtask

  // sender goes quiet until everything is back, then resumes
  task automatic test_quiet_restart();
    repeat (20) send_random_command();
    wait_for_results();
    repeat (20) send_random_command();
  endtask

  // random phases over lengths, loop modes and rates
  task automatic test_random_sessions();
    logic [31:0] length;
    logic [15:0] speed;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0: length = 32'd0;
        1: length = TIME_MAX;
        2: length = $urandom_range(1, 4);
        3: length = $urandom;
        default: length = $urandom_range(1, 32'h0040_0000);
      endcase
      case ($urandom_range(0, 5))
        0: speed = RATE_RESET;
        1: speed = 16'd0;
        2: speed = 16'hFFFF;
        3: speed = 16'($urandom_range(1, 16'hFFFF));
        default: speed = 16'($urandom_range(64, 1024));
      endcase
      if (phase == 0) speed = 16'd0;
      if (phase == 1) speed = 16'hFFFF;
      set_config(length, 1'($urandom_range(0, 1)), speed);
      repeat (75) send_random_command();
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // result side: stall pattern and field checks on every transfer
  initial begin : result_checker
    int      open_left;
    int      stall_left;
    int      hold_left;
    status_t want;
    open_left  = 0;
    stall_left = 0;
    hold_left  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_status.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with none expected, expected none, actual %h",
                     $time, m_tdata);
        end else begin
          want = pending_status.pop_front();
          if (m_tdata[1:0] !== want.state)
            note_mismatch("run_state_out", {30'd0, want.state}, {30'd0, m_tdata[1:0]});
          if (m_tdata[33:2] !== want.position)
            note_mismatch("position_out", want.position, m_tdata[33:2]);
          if (m_tdata[34] !== want.wrapped)
            note_mismatch("wrapped", {31'd0, want.wrapped}, {31'd0, m_tdata[34]});
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (open_left > 0) begin
          open_left--;
        end else begin
          // a ready run then a stall, now and then a long open stretch
          open_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                   : $urandom_range(0, 12);
          stall_left = $urandom_range(1, 9);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    clip_len   = 32'd0;
    loop_on    = 1'b0;
    rate       = RATE_RESET;
    trk_state  = RS_INIT;
    trk_pos    = 32'd0;
    trk_looped = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_zero_length();
    test_clamp_complete();
    test_loop_wrap();
    test_saturation();
    test_output_stall();
    test_quiet_restart();
    test_random_sessions();
    wait_for_results();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
